### rtl/core/bma_pkg.sv
package bma_pkg;

  localparam int NUM_BINS_DEF = 32;

  localparam logic [19:0] COUNT_MAX     = 20'hFFFFF;
  localparam logic [15:0] KEY_LOW_RST   = 16'h0000;
  localparam logic [15:0] KEY_HIGH_RST  = 16'hFFFF;
  localparam logic [15:0] BIN_WIDTH_RST = 16'd2048;

  // iterative unit
  localparam int ALU_A_W    = 88;
  localparam int ALU_CNT_W  = 7;
  localparam int MUL_STEPS  = 64;
  localparam int DIV_STEPS  = 88;
  localparam int SQRT_STEPS = 32;

  localparam logic [87:0] SIX_2P24 = 88'd100663296;   // 6 * 2^24
  localparam logic [39:0] VAR_MAX  = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_KEY_LOW   = 2'd0,
    CFG_KEY_HIGH  = 2'd1,
    CFG_BIN_WIDTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DIV,
    T_MOD,
    T_RDATA,
    T_STATS,
    T_PUSH
  } top_state_t;

  typedef enum logic [4:0] {
    SS_IDLE,
    SS_GO,
    SS_MEAN,
    SS_NQ,
    SS_SQ,
    SS_DEN,
    SS_VAR,
    SS_SIG,
    SS_VN,
    SS_ME,
    SS_SE6,
    SS_SE,
    SS_M12,
    SS_C64,
    SS_P,
    SS_M2,
    SS_M3,
    SS_S12,
    SS_S2,
    SS_S3,
    SS_SK
  } stats_state_t;

  typedef struct packed {
    logic [19:0]        cnt;
    logic signed [31:0] sum;
    logic [41:0]        sq;
    logic signed [53:0] cube;
  } bin_entry_t;

  typedef struct packed {
    logic signed [11:0] mean;
    logic [11:0]        sigma;
    logic [11:0]        mean_error;
    logic signed [15:0] skewness;
    logic [12:0]        skew_error;
  } stats_res_t;

endpackage

### rtl/core/bma_alu.sv
module bma_alu (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  bma_pkg::alu_op_t                  op,
  input  logic [bma_pkg::ALU_A_W-1:0]       a,
  input  logic [63:0]                       b,
  output logic                              done,
  output logic [63:0]                       res,
  output logic [63:0]                       rem
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  bma_pkg::alu_op_t                    op_r, op_nxt;
  logic [bma_pkg::ALU_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [63:0]                         acc_r, acc_nxt;
  logic [bma_pkg::ALU_A_W-1:0]         x_r, x_nxt;
  logic [63:0]                         y_r, y_nxt;

  logic [64:0] rsh;
  logic [64:0] rdiff;
  logic [63:0] rb;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rsh      = {acc_r, x_r[bma_pkg::ALU_A_W-1]};
    rdiff    = rsh - {1'b0, y_r};
    rb       = acc_r + y_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      acc_nxt  = '0;
      x_nxt    = a;
      y_nxt    = b;
      case (op)
        bma_pkg::ALU_MUL:  cnt_nxt = bma_pkg::ALU_CNT_W'(bma_pkg::MUL_STEPS - 1);
        bma_pkg::ALU_DIV:  cnt_nxt = bma_pkg::ALU_CNT_W'(bma_pkg::DIV_STEPS - 1);
        bma_pkg::ALU_SQRT: begin
          cnt_nxt = bma_pkg::ALU_CNT_W'(bma_pkg::SQRT_STEPS - 1);
          y_nxt   = 64'h4000_0000_0000_0000;
        end
        default:           cnt_nxt = '0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        bma_pkg::ALU_MUL: begin
          acc_nxt = acc_r + (y_r[0] ? x_r[63:0] : 64'd0);
          x_nxt   = x_r << 1;
          y_nxt   = y_r >> 1;
        end
        bma_pkg::ALU_DIV: begin
          // restoring, one quotient bit a step
          if (!rdiff[64]) begin
            acc_nxt = rdiff[63:0];
          end else begin
            acc_nxt = rsh[63:0];
          end
          x_nxt = {x_r[bma_pkg::ALU_A_W-2:0], ~rdiff[64]};
        end
        bma_pkg::ALU_SQRT: begin
          if (x_r[63:0] >= rb) begin
            x_nxt   = {x_r[bma_pkg::ALU_A_W-1:64], x_r[63:0] - rb};
            acc_nxt = (acc_r >> 1) + y_r;
          end else begin
            acc_nxt = acc_r >> 1;
          end
          y_nxt = y_r >> 2;
        end
        default: acc_nxt = acc_r;
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == bma_pkg::ALU_DIV) ? x_r[63:0] : acc_r;
  assign rem  = (op_r == bma_pkg::ALU_SQRT) ? x_r[63:0] : acc_r;

endmodule

### rtl/core/bma_stats.sv
module bma_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bma_pkg::bin_entry_t ent,
  output logic                done,
  output bma_pkg::stats_res_t res
);

  bma_pkg::stats_state_t state_r, state_nxt;
  logic                  done_r, done_nxt;

  logic [19:0] n_r, n_nxt;
  logic [31:0] sa_r, sa_nxt;
  logic        sneg_r, sneg_nxt;
  logic [41:0] qs_r, qs_nxt;
  logic [53:0] ca_r, ca_nxt;
  logic        cneg_r, cneg_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [39:0] v_r, v_nxt;
  logic [17:0] m12_r, m12_nxt;
  logic [63:0] t_r, t_nxt;
  logic [26:0] s12_r, s12_nxt;
  bma_pkg::stats_res_t out_r, out_nxt;

  logic                          alu_start;
  bma_pkg::alu_op_t              alu_op;
  logic [bma_pkg::ALU_A_W-1:0]   alu_a;
  logic [63:0]                   alu_b;
  logic                          alu_done;
  logic [63:0]                   r;
  logic [63:0]                   rm;

  logic [63:0] rnd;
  logic [39:0] vs;
  logic [63:0] p3;
  logic [63:0] r3;
  logic [63:0] tm;

  bma_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .res   (r),
    .rem   (rm)
  );

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    n_nxt     = n_r;
    sa_nxt    = sa_r;
    sneg_nxt  = sneg_r;
    qs_nxt    = qs_r;
    ca_nxt    = ca_r;
    cneg_nxt  = cneg_r;
    tmp_nxt   = tmp_r;
    v_nxt     = v_r;
    m12_nxt   = m12_r;
    t_nxt     = t_r;
    s12_nxt   = s12_r;
    out_nxt   = out_r;
    alu_start = 1'b0;
    alu_op    = bma_pkg::ALU_MUL;
    alu_a     = '0;
    alu_b     = '0;
    // rounded square root: bump when remainder exceeds root
    rnd = r + 64'(rm > r);
    vs  = (|r[63:40]) ? bma_pkg::VAR_MAX : r[39:0];
    p3  = r + (r << 1);
    r3  = (r + 64'd2048) >> 12;
    tm  = t_r[63] ? (64'd0 - t_r) : t_r;

    case (state_r)
      bma_pkg::SS_IDLE: begin
        if (start) begin
          n_nxt     = ent.cnt;
          sneg_nxt  = ent.sum[31];
          sa_nxt    = ent.sum[31] ? (32'd0 - ent.sum) : ent.sum;
          qs_nxt    = ent.sq;
          cneg_nxt  = ent.cube[53];
          ca_nxt    = ent.cube[53] ? (54'd0 - ent.cube) : ent.cube;
          state_nxt = bma_pkg::SS_GO;
        end
      end
      bma_pkg::SS_GO: begin
        alu_start = 1'b1;
        alu_op    = bma_pkg::ALU_DIV;
        alu_a     = bma_pkg::ALU_A_W'({sa_r, 1'b0}) + bma_pkg::ALU_A_W'(n_r);
        alu_b     = 64'({n_r, 1'b0});
        state_nxt = bma_pkg::SS_MEAN;
      end
      default: begin
        if (alu_done) begin
          alu_start = 1'b1;
          case (state_r)
            bma_pkg::SS_MEAN: begin
              out_nxt.mean = sneg_r ? 12'(64'd0 - r) : r[11:0];
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(qs_r);
              alu_b     = 64'(n_r);
              state_nxt = bma_pkg::SS_NQ;
            end
            bma_pkg::SS_NQ: begin
              tmp_nxt   = r;
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(sa_r);
              alu_b     = 64'(sa_r);
              state_nxt = bma_pkg::SS_SQ;
            end
            bma_pkg::SS_SQ: begin
              // negative variance numerator clamps to zero
              tmp_nxt   = (tmp_r >= r) ? (tmp_r - r) : 64'd0;
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(n_r);
              alu_b     = 64'(n_r - 20'd1);
              state_nxt = bma_pkg::SS_DEN;
            end
            bma_pkg::SS_DEN: begin
              alu_op    = bma_pkg::ALU_DIV;
              alu_a     = bma_pkg::ALU_A_W'(tmp_r);
              alu_b     = r;
              state_nxt = bma_pkg::SS_VAR;
            end
            bma_pkg::SS_VAR: begin
              v_nxt     = vs;
              alu_op    = bma_pkg::ALU_SQRT;
              alu_a     = bma_pkg::ALU_A_W'(vs);
              state_nxt = bma_pkg::SS_SIG;
            end
            bma_pkg::SS_SIG: begin
              out_nxt.sigma = (|rnd[63:12]) ? 12'hFFF : rnd[11:0];
              alu_op    = bma_pkg::ALU_DIV;
              alu_a     = bma_pkg::ALU_A_W'(v_r);
              alu_b     = 64'(n_r);
              state_nxt = bma_pkg::SS_VN;
            end
            bma_pkg::SS_VN: begin
              alu_op    = bma_pkg::ALU_SQRT;
              alu_a     = bma_pkg::ALU_A_W'(r);
              state_nxt = bma_pkg::SS_ME;
            end
            bma_pkg::SS_ME: begin
              out_nxt.mean_error = (|rnd[63:12]) ? 12'hFFF : rnd[11:0];
              alu_op    = bma_pkg::ALU_DIV;
              alu_a     = bma_pkg::SIX_2P24;
              alu_b     = 64'(n_r);
              state_nxt = bma_pkg::SS_SE6;
            end
            bma_pkg::SS_SE6: begin
              alu_op    = bma_pkg::ALU_SQRT;
              alu_a     = bma_pkg::ALU_A_W'(r);
              state_nxt = bma_pkg::SS_SE;
            end
            bma_pkg::SS_SE: begin
              out_nxt.skew_error = rnd[12:0];
              alu_op    = bma_pkg::ALU_DIV;
              alu_a     = bma_pkg::ALU_A_W'({sa_r, 7'd0}) + bma_pkg::ALU_A_W'(n_r);
              alu_b     = 64'({n_r, 1'b0});
              state_nxt = bma_pkg::SS_M12;
            end
            bma_pkg::SS_M12: begin
              m12_nxt   = r[17:0];
              alu_op    = bma_pkg::ALU_DIV;
              alu_a     = bma_pkg::ALU_A_W'({ca_r, 7'd0}) + bma_pkg::ALU_A_W'(n_r);
              alu_b     = 64'({n_r, 1'b0});
              state_nxt = bma_pkg::SS_C64;
            end
            bma_pkg::SS_C64: begin
              t_nxt     = cneg_r ? (64'd0 - r) : r;
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(m12_r);
              alu_b     = 64'(v_r);
              state_nxt = bma_pkg::SS_P;
            end
            bma_pkg::SS_P: begin
              // t -= 3*m12*v, m12 carries the sign of the sum
              t_nxt     = sneg_r ? (t_r + p3) : (t_r - p3);
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(m12_r);
              alu_b     = 64'(m12_r);
              state_nxt = bma_pkg::SS_M2;
            end
            bma_pkg::SS_M2: begin
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(r);
              alu_b     = 64'(m12_r);
              state_nxt = bma_pkg::SS_M3;
            end
            bma_pkg::SS_M3: begin
              t_nxt     = sneg_r ? (t_r + r3) : (t_r - r3);
              alu_op    = bma_pkg::ALU_SQRT;
              alu_a     = bma_pkg::ALU_A_W'({v_r, 12'd0});
              state_nxt = bma_pkg::SS_S12;
            end
            bma_pkg::SS_S12: begin
              s12_nxt   = r[26:0];
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(r[26:0]);
              alu_b     = 64'(r[26:0]);
              state_nxt = bma_pkg::SS_S2;
            end
            bma_pkg::SS_S2: begin
              alu_op    = bma_pkg::ALU_MUL;
              alu_a     = bma_pkg::ALU_A_W'(r);
              alu_b     = 64'(s12_r);
              state_nxt = bma_pkg::SS_S3;
            end
            bma_pkg::SS_S3: begin
              if (s12_r == '0) begin
                alu_start        = 1'b0;
                out_nxt.skewness = '0;
                done_nxt         = 1'b1;
                state_nxt        = bma_pkg::SS_IDLE;
              end else if (tm >= r) begin
                alu_start        = 1'b0;
                out_nxt.skewness = t_r[63] ? 16'sh8000 : 16'sh7FFF;
                done_nxt         = 1'b1;
                state_nxt        = bma_pkg::SS_IDLE;
              end else begin
                alu_op    = bma_pkg::ALU_DIV;
                alu_a     = {tm, 24'd0};
                alu_b     = r;
                state_nxt = bma_pkg::SS_SK;
              end
            end
            bma_pkg::SS_SK: begin
              alu_start = 1'b0;
              if (t_r[63]) begin
                out_nxt.skewness = (r > 64'd32768) ? 16'sh8000 : 16'(64'd0 - r);
              end else begin
                out_nxt.skewness = (r > 64'd32767) ? 16'sh7FFF : r[15:0];
              end
              done_nxt  = 1'b1;
              state_nxt = bma_pkg::SS_IDLE;
            end
            default: begin
              alu_start = 1'b0;
              state_nxt = bma_pkg::SS_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bma_pkg::SS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    sa_r   <= sa_nxt;
    sneg_r <= sneg_nxt;
    qs_r   <= qs_nxt;
    ca_r   <= ca_nxt;
    cneg_r <= cneg_nxt;
    tmp_r  <= tmp_nxt;
    v_r    <= v_nxt;
    m12_r  <= m12_nxt;
    t_r    <= t_nxt;
    s12_r  <= s12_nxt;
    out_r  <= out_nxt;
  end

  assign done = done_r;
  assign res  = out_r;

endmodule

### rtl/core/binned_moment_accumulator.sv
// Accumulate: one key-divider step per index bit (the last one also issues the store read),
//   then one read-modify-write; clear and unused operations are taken without leaving idle.
// Read: statistics come from the shared bit-serial mul/div/sqrt unit (up to 19 operations).
// Results sit in an output register; accumulate and clear words go on while it waits.
// Reset (rst_n, synchronous, active low): all bins empty via per-bin valid bits,
//   key_low 0, key_high 65535, bin_width 2048.
module binned_moment_accumulator #(
  parameter int NUM_BINS = bma_pkg::NUM_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_key,
  input  logic signed [11:0] in_sample_value,
  input  logic [4:0]         in_bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [19:0]        out_bin_count,
  output logic signed [11:0] out_mean,
  output logic [11:0]        out_sigma,
  output logic [11:0]        out_mean_error,
  output logic signed [15:0] out_skewness,
  output logic [12:0]        out_skew_error,
  output logic               out_stats_valid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int CHK_W  = 16 + IDX_W + 1;
  localparam int DSR_W  = 16 + IDX_W;

  bma_pkg::top_state_t state_r, state_nxt;

  logic [15:0] key_low_r, key_high_r, bin_width_r;

  logic signed [11:0] x_r, x_nxt;
  logic [22:0]        x2_r, x2_nxt;
  logic signed [35:0] x3_r;
  logic signed [23:0] sq_full;
  logic signed [35:0] cube_full;

  logic [15:0]       rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic              ge;
  logic [CHK_W-1:0]  span;

  bma_pkg::bin_entry_t mem_r [NUM_BINS];
  logic [NUM_BINS-1:0] valid_r;
  bma_pkg::bin_entry_t rdata_r;
  logic                rvld_r;
  bma_pkg::bin_entry_t ent;
  bma_pkg::bin_entry_t wdata;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;
  logic                clr;

  logic [19:0] cnt_out_r, cnt_out_nxt;
  logic        use_stats_r, use_stats_nxt;

  logic                stats_start;
  logic                stats_done;
  bma_pkg::stats_res_t stats_res;

  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic [19:0]         out_cnt_r;
  bma_pkg::stats_res_t out_res_r;
  logic                out_sv_r;

  logic accept;
  logic key_ok;

  bma_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .start (stats_start),
    .ent   (ent),
    .done  (stats_done),
    .res   (stats_res)
  );

  assign in_ready  = (state_r == bma_pkg::T_IDLE);
  assign accept    = in_valid && in_ready;
  assign ent       = rvld_r ? rdata_r : '0;
  assign sq_full   = in_sample_value * in_sample_value;
  assign cube_full = x_r * $signed({1'b0, x2_r});
  assign span      = CHK_W'(NUM_BINS) * CHK_W'(bin_width_r);
  assign key_ok    = (in_key > key_low_r) && (in_key < key_high_r) && (bin_width_r != 16'd0)
                     && (CHK_W'(in_key - key_low_r) < span);
  assign ge        = (DSR_W'(rem_r) >= dsr_r);

  always_comb begin
    wdata.cnt  = ent.cnt + 20'd1;
    wdata.sum  = ent.sum + 32'(x_r);
    wdata.sq   = ent.sq + 42'(x2_r);
    wdata.cube = ent.cube + 54'(x3_r);
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    wr_addr_nxt   = wr_addr_r;
    cnt_out_nxt   = cnt_out_r;
    use_stats_nxt = use_stats_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mem_we        = 1'b0;
    clr           = 1'b0;
    stats_start   = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      bma_pkg::T_IDLE: begin
        if (accept) begin
          case (bma_pkg::op_t'(in_operation))
            bma_pkg::OP_ACC: begin
              x_nxt  = in_sample_value;
              x2_nxt = sq_full[22:0];
              if (key_ok) begin
                rem_nxt   = in_key - key_low_r;
                dsr_nxt   = DSR_W'(bin_width_r) << (IDX_W - 1);
                q_nxt     = '0;
                step_nxt  = STEP_W'(IDX_W - 1);
                state_nxt = bma_pkg::T_DIV;
              end
            end
            bma_pkg::OP_READ: begin
              if (32'(in_bin_index) >= 32'(NUM_BINS)) begin
                // out-of-range bin reads as empty
                cnt_out_nxt   = '0;
                use_stats_nxt = 1'b0;
                state_nxt     = bma_pkg::T_PUSH;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_bin_index);
                state_nxt = bma_pkg::T_RDATA;
              end
            end
            bma_pkg::OP_CLEAR: clr = 1'b1;
            default:           clr = 1'b0;
          endcase
        end
      end
      bma_pkg::T_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dsr_r[15:0];
        end
        q_nxt   = (q_r << 1) | IDX_W'(ge);
        dsr_nxt = dsr_r >> 1;
        if (step_r == '0) begin
          rd_en       = 1'b1;
          rd_addr     = q_nxt;
          wr_addr_nxt = q_nxt;
          state_nxt   = bma_pkg::T_MOD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      bma_pkg::T_MOD: begin
        mem_we    = (ent.cnt != bma_pkg::COUNT_MAX);
        state_nxt = bma_pkg::T_IDLE;
      end
      bma_pkg::T_RDATA: begin
        cnt_out_nxt = ent.cnt;
        if (ent.cnt > 20'd1) begin
          stats_start = 1'b1;
          state_nxt   = bma_pkg::T_STATS;
        end else begin
          use_stats_nxt = 1'b0;
          state_nxt     = bma_pkg::T_PUSH;
        end
      end
      bma_pkg::T_STATS: begin
        if (stats_done) begin
          use_stats_nxt = 1'b1;
          state_nxt     = bma_pkg::T_PUSH;
        end
      end
      bma_pkg::T_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bma_pkg::T_IDLE;
        end
      end
      default: state_nxt = bma_pkg::T_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bma_pkg::T_IDLE;
      out_valid_r <= 1'b0;
      key_low_r   <= bma_pkg::KEY_LOW_RST;
      key_high_r  <= bma_pkg::KEY_HIGH_RST;
      bin_width_r <= bma_pkg::BIN_WIDTH_RST;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (bma_pkg::cfg_idx_t'(cfg_index))
          bma_pkg::CFG_KEY_LOW:   key_low_r   <= cfg_wdata;
          bma_pkg::CFG_KEY_HIGH:  key_high_r  <= cfg_wdata;
          bma_pkg::CFG_BIN_WIDTH: bin_width_r <= cfg_wdata;
          default:                key_low_r   <= key_low_r;
        endcase
      end
      if (clr) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[wr_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    x2_r        <= x2_nxt;
    x3_r        <= cube_full;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    q_r         <= q_nxt;
    step_r      <= step_nxt;
    wr_addr_r   <= wr_addr_nxt;
    cnt_out_r   <= cnt_out_nxt;
    use_stats_r <= use_stats_nxt;
    if (out_load) begin
      out_cnt_r <= cnt_out_r;
      out_res_r <= use_stats_r ? stats_res : '0;
      out_sv_r  <= use_stats_r;
    end
  end

  // bin store: one write, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
      rvld_r  <= valid_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_count   = out_cnt_r;
  assign out_mean        = out_res_r.mean;
  assign out_sigma       = out_res_r.sigma;
  assign out_mean_error  = out_res_r.mean_error;
  assign out_skewness    = out_res_r.skewness;
  assign out_skew_error  = out_res_r.skew_error;
  assign out_stats_valid = out_sv_r;

  a_sv_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sv_r == (out_cnt_r > 20'd1)))
    else $error("stats_valid disagrees with bin count");

  a_done_in_stats: assert property (@(posedge clk) disable iff (!rst_n)
    stats_done |-> (state_r == bma_pkg::T_STATS))
    else $error("stats done outside of a read");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(wr_addr_r) < 32'(NUM_BINS)))
    else $error("bin write beyond NUM_BINS");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> !mem_we)
    else $error("clear collides with a bin write");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NB = bma_pkg::NUM_BINS_DEF;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE = 3 * NB;

  typedef struct {
    logic [19:0]        cnt;
    logic signed [11:0] mean;
    logic [11:0]        sigma;
    logic [11:0]        merr;
    logic signed [15:0] skew;
    logic [12:0]        serr;
    logic               ok;
  } stat_t;

  typedef struct {
    bma_pkg::op_t op;
    logic [15:0]  key;
    logic [11:0]  val;
    logic [4:0]   idx;
    bit           typed;
    stat_t        ex;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_operation = 0;
  logic [15:0] in_key = 0;
  logic signed [11:0] in_sample_value = 0;
  logic [4:0] in_bin_index = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [19:0] out_bin_count;
  logic signed [11:0] out_mean;
  logic [11:0] out_sigma;
  logic [11:0] out_mean_error;
  logic signed [15:0] out_skewness;
  logic [12:0] out_skew_error;
  logic out_stats_valid;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_wdata = 0;

  binned_moment_accumulator dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [15:0] lo_q, hi_q, width_q;
  logic [19:0] cnt_q [NB];
  longint      sum_q [NB];
  longint      sq_q [NB];
  longint      cube_q [NB];

  stat_t stats_q[$];
  int errors = 0;
  bit quiet = 0;
  longint cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned rsqrt(longint unsigned x);
    longint unsigned r;
    r = isqrt(x);
    if (x - r * r > r) r++;
    return r;
  endfunction

  // half away from zero
  function automatic longint div_rnd(longint a, longint unsigned d);
    longint unsigned m, q;
    m = (a < 0) ? longint'(-a) : a;
    q = (2 * m + d) / (2 * d);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic stat_t bin_stats(int b);
    stat_t r;
    longint unsigned n, d, v, s12, s3, mag, q;
    longint s, qs, c, num, m12, t, sk;
    r = '{default: 0};
    n = 64'(cnt_q[b]);
    r.cnt = cnt_q[b];
    if (n <= 1) return r;
    s = sum_q[b];
    qs = sq_q[b];
    c = cube_q[b];
    r.mean = 12'(div_rnd(s, n));
    num = longint'(n) * qs - s * s;
    if (num < 0) num = 0;
    d = n * (n - 1);
    v = longint'(num) / d;
    if (v > bma_pkg::VAR_MAX) v = 64'(bma_pkg::VAR_MAX);
    q = rsqrt(v);
    r.sigma = 12'((q > 4095) ? 4095 : q);
    q = rsqrt(v / n);
    r.merr = 12'((q > 4095) ? 4095 : q);
    r.serr = 13'(rsqrt((64'd6 << 24) / n));
    m12 = div_rnd(s * 64, n);
    t = div_rnd(c * 64, n) - 3 * m12 * longint'(v) - div_rnd(m12 * m12 * m12, 4096);
    s12 = isqrt(v * 4096);
    sk = 0;
    if (s12 != 0) begin
      s3 = s12 * s12 * s12;
      mag = (t < 0) ? longint'(-t) : t;
      if (mag >= s3) q = 64'd1 << 16;
      else begin
        q = 0;
        for (int i = 0; i < 24; i++) begin
          mag <<= 1;
          q <<= 1;
          if (mag >= s3) begin
            mag -= s3;
            q |= 1;
          end
        end
      end
      if (t < 0) sk = (q > 32768) ? -32768 : -longint'(q);
      else sk = (q > 32767) ? 32767 : longint'(q);
    end
    r.skew = 16'(sk);
    r.ok = 1;
    return r;
  endfunction

  function automatic void wipe_bins();
    for (int i = 0; i < NB; i++) begin
      cnt_q[i] = '0;
      sum_q[i] = 0;
      sq_q[i] = 0;
      cube_q[i] = 0;
    end
  endfunction

  function automatic void apply_word(row_t w);
    longint x;
    int unsigned b;
    x = longint'($signed(w.val));
    case (w.op)
      bma_pkg::OP_ACC: begin
        if (w.key > lo_q && w.key < hi_q && width_q != 0) begin
          b = (32'(w.key) - 32'(lo_q)) / 32'(width_q);
          if (b < NB && cnt_q[b] < bma_pkg::COUNT_MAX) begin
            cnt_q[b]++;
            sum_q[b] += x;
            sq_q[b] += x * x;
            cube_q[b] += x * x * x;
          end
        end
      end
      bma_pkg::OP_READ: stats_q.push_back(w.typed ? w.ex : bin_stats(int'(w.idx)));
      bma_pkg::OP_CLEAR: wipe_bins();
      default: ;
    endcase
  endfunction

  task automatic send(row_t w);
    in_valid <= 1;
    in_operation <= w.op;
    in_key <= w.key;
    in_sample_value <= w.val;
    in_bin_index <= w.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cfg(logic [15:0] lo, logic [15:0] hi, logic [15:0] wd);
    cfg_we <= 1;
    cfg_index <= bma_pkg::CFG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= bma_pkg::CFG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= bma_pkg::CFG_BIN_WIDTH;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_we <= 0;
    lo_q = lo;
    hi_q = hi;
    width_q = wd;
  endtask

  function automatic row_t mk(bma_pkg::op_t op, int key, int val, int idx);
    row_t r;
    r.op = op;
    r.key = 16'(key);
    r.val = 12'(val);
    r.idx = 5'(idx);
    r.typed = 0;
    r.ex = '{default: 0};
    return r;
  endfunction

  // typed expectation: count only, everything else zero
  function automatic row_t mk_rd(int idx, int cnt);
    row_t r;
    r = mk(bma_pkg::OP_READ, 0, 0, idx);
    r.typed = 1;
    r.ex.cnt = 20'(cnt);
    return r;
  endfunction

  function automatic logic [15:0] rand_key();
    if ($urandom_range(0, 9) < 8 && int'(hi_q) > int'(lo_q) + 1)
      return 16'($urandom_range(32'(lo_q) + 1, 32'(hi_q) - 1));
    return 16'($urandom);
  endfunction

  function automatic logic [11:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'($urandom_range(0, 7) - 4);
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic check(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got count %0d", $time, out_bin_count);
        errors++;
      end else begin
        e = stats_q.pop_front();
        check("bin_count", e.cnt, out_bin_count);
        check("mean", e.mean, out_mean);
        check("sigma", e.sigma, out_sigma);
        check("mean_error", e.merr, out_mean_error);
        check("skewness", e.skew, out_skewness);
        check("skew_error", e.serr, out_skew_error);
        check("stats_valid", e.ok, out_stats_valid);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      out_ready <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    row_t dir[$];
    row_t w;
    int b, n;
    logic [15:0] k;
    lo_q = bma_pkg::KEY_LOW_RST;
    hi_q = bma_pkg::KEY_HIGH_RST;
    width_q = bma_pkg::BIN_WIDTH_RST;
    wipe_bins();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir.push_back(mk_rd(0, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'h0000, 5, 0));      // key on lower bound
    dir.push_back(mk(bma_pkg::OP_ACC, 16'hFFFF, 5, 0));      // key on upper bound
    dir.push_back(mk(bma_pkg::OP_ACC, 1, -2048, 0));
    dir.push_back(mk_rd(0, 1));
    dir.push_back(mk(bma_pkg::OP_ACC, 2047, 2047, 0));
    dir.push_back(mk(bma_pkg::OP_READ, 0, 0, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'hFFFE, 0, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'hFFFE, 0, 0));
    dir.push_back(mk(bma_pkg::OP_READ, 0, 0, 31));           // zero sigma
    dir.push_back(mk(bma_pkg::OP_ACC, 16'h5555, 12'h555, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'hAAAA, 12'hAAA, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'h5800, -1, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'h5801, 3, 0));
    dir.push_back(mk(bma_pkg::OP_ACC, 16'h5802, -100, 0));
    dir.push_back(mk(bma_pkg::OP_READ, 0, 0, 11));
    dir.push_back(mk(bma_pkg::OP_READ, 0, 0, 10));
    dir.push_back(mk(bma_pkg::OP_NONE, 16'h1234, 7, 0));
    dir.push_back(mk(bma_pkg::OP_READ, 0, 0, 21));
    dir.push_back(mk(bma_pkg::OP_CLEAR, 0, 0, 0));
    dir.push_back(mk_rd(0, 0));
    dir.push_back(mk_rd(31, 0));
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ;
        1: set_cfg(16'd0, 16'hFFFF, 16'hFFFF);
        2: set_cfg(16'd100, 16'd5000, 16'd1);
        3: set_cfg(16'hFFFF, 16'd0, 16'd2048);
        4: set_cfg(16'd0, 16'hFFFF, 16'd0);
        9: set_cfg(16'd0, 16'hFFFF, 16'd2048);
        default: begin
          k = 16'($urandom_range(0, 30000));
          set_cfg(k, 16'($urandom_range(32'(k) + 2, 65535)), 16'($urandom_range(1, 4096)));
        end
      endcase
      if (ph == 9) quiet = 1;
      n = 0;
      while (n < 160) begin
        if ($urandom_range(0, 5) == 0) begin
          // many words into one bin, a rare outlier, then read it back
          k = rand_key();
          b = int'($urandom_range(5, 100));
          for (int j = 0; j < b; j++)
            send(mk(bma_pkg::OP_ACC, int'(k),
                    ($urandom_range(0, 19) == 0) ? int'($signed(rand_val()))
                                                 : int'($urandom_range(0, 3)), 0));
          if (width_q != 0 && k > lo_q)
            send(mk(bma_pkg::OP_READ, 0, 0, int'((k - lo_q) / width_q)));
          n += b + 1;
        end else begin
          b = int'($urandom_range(0, 99));
          w = mk(bma_pkg::OP_ACC, int'(rand_key()), int'($signed(rand_val())), int'($urandom));
          if (b >= 98) w.op = bma_pkg::OP_NONE;
          else if (b >= 96) w.op = bma_pkg::OP_CLEAR;
          else if (b >= 86) w.op = bma_pkg::OP_READ;
          send(w);
          n++;
        end
      end
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
